>>> src/search_transposition_table_defines.svh
// Assertion macros for the search transposition table.
// Included by the top level; no other dependencies.
`ifndef SEARCH_TRANSPOSITION_TABLE_DEFINES_SVH
`define SEARCH_TRANSPOSITION_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define STT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stt: implication check failed");
// next-cycle implication, disabled while reset is asserted
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stt: next-cycle check failed");
`else
`define STT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/stt_pkg.sv
// Types and constants shared by the search transposition table modules.
// No dependencies.
`timescale 1ns / 1ps

package stt_pkg;

    // hash split: tag is the upper 32 bits, index comes from the lower word
    localparam int unsigned STT_TAG_LSB = 32;
    localparam int unsigned STT_TAG_W   = 32;
    localparam int unsigned STT_KEY_W   = 32;

    // front queue
    localparam int unsigned STT_Q_DEPTH = 2;
    localparam int unsigned STT_Q_PTR_W = 1;
    localparam int unsigned STT_Q_CNT_W = 2;

    typedef enum logic [1:0] {
        OP_READ_MAIN    = 2'd0,
        OP_UPDATE_MAIN  = 2'd1,
        OP_READ_QUIES   = 2'd2,
        OP_UPDATE_QUIES = 2'd3
    } t_stt_op;

    typedef enum logic [1:0] {
        KIND_EXACT = 2'd0,
        KIND_UPPER = 2'd1,
        KIND_LOWER = 2'd2
    } t_stt_kind;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } t_stt_state;

    // input word
    typedef struct packed {
        t_stt_op            opcode;
        logic [63:0]        hash;
        logic [6:0]         depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic signed [15:0] score;
    } t_stt_in;

    // result word
    typedef struct packed {
        logic               hit;
        logic signed [15:0] result_value;
        logic signed [15:0] alpha_out;
        logic signed [15:0] beta_out;
    } t_stt_out;

    // one table entry as stored in memory
    typedef struct packed {
        logic [STT_TAG_W-1:0] tag;
        logic signed [15:0]   score;
        logic [6:0]           depth;
        t_stt_kind            kind;
    } t_stt_entry;

    localparam int unsigned STT_ENTRY_W = $bits(t_stt_entry);

    // classified job handed from front to back
    typedef struct packed {
        logic                 is_update;
        logic                 is_quies;
        logic [STT_TAG_W-1:0] tag;
        logic [STT_KEY_W-1:0] key_lo;
        logic [6:0]           depth;
        logic signed [15:0]   alpha;
        logic signed [15:0]   beta;
        logic signed [15:0]   score;
    } t_stt_job;

    // back-end status toward the front
    typedef struct packed {
        logic clear_done;
        logic pop;
    } t_stt_back_stat;

endpackage

>>> src/stt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module stt_ram #(
    parameter int unsigned WIDTH = 57,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/stt_front.sv
// Front end: accepts input words, decodes the opcode into a job and queues it.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_front
    import stt_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  t_stt_in        i_in_word,
    output logic           o_q_valid,
    output t_stt_job       o_q_job,
    input  t_stt_back_stat i_back_stat
);

    t_stt_job                r_q [STT_Q_DEPTH];
    logic [STT_Q_PTR_W-1:0]  r_wr_ptr;
    logic [STT_Q_PTR_W-1:0]  r_rd_ptr;
    logic [STT_Q_CNT_W-1:0]  r_count;
    logic                    w_accept;
    logic                    w_pop;
    t_stt_job                w_job;

    // no words taken while the tables are being cleared
    assign o_in_ready = (r_count != STT_Q_CNT_W'(STT_Q_DEPTH)) && i_back_stat.clear_done;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pop      = i_back_stat.pop;

    // classify the word
    always_comb begin
        w_job.is_update = (i_in_word.opcode == OP_UPDATE_MAIN) ||
                          (i_in_word.opcode == OP_UPDATE_QUIES);
        w_job.is_quies  = (i_in_word.opcode == OP_READ_QUIES) ||
                          (i_in_word.opcode == OP_UPDATE_QUIES);
        w_job.tag       = i_in_word.hash[STT_TAG_LSB +: STT_TAG_W];
        w_job.key_lo    = i_in_word.hash[STT_KEY_W-1:0];
        w_job.depth     = i_in_word.depth;
        w_job.alpha     = i_in_word.alpha;
        w_job.beta      = i_in_word.beta;
        w_job.score     = i_in_word.score;
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_accept) begin
                r_wr_ptr <= r_wr_ptr + STT_Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + STT_Q_PTR_W'(1);
            end
            unique case ({w_accept, w_pop})
                2'b10:   r_count <= r_count + STT_Q_CNT_W'(1);
                2'b01:   r_count <= r_count - STT_Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_job   = r_q[r_rd_ptr];

endmodule

>>> src/stt_back.sv
// Back end: clears the tables after reset, then reads both tables for each
// job, evaluates the entries and writes updates or loads the result register.
// Depends on stt_pkg and stt_ram.
`timescale 1ns / 1ps

module stt_back
    import stt_pkg::*;
#(
    parameter int unsigned INDEX_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  t_stt_job       i_q_job,
    output t_stt_back_stat o_back_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output t_stt_out       o_out_word
);

    localparam int unsigned Depth = 2 ** INDEX_BITS;

    t_stt_state             r_state, n_state;
    logic [INDEX_BITS-1:0]  r_clr_addr, n_clr_addr;
    t_stt_job               r_cur, n_cur;
    logic                   r_out_valid, n_out_valid;
    t_stt_out               r_out_word, n_out_word;

    logic                   w_rd_en;
    logic [INDEX_BITS-1:0]  w_rd_addr;
    logic                   w_wr_main;
    logic                   w_wr_quies;
    logic [INDEX_BITS-1:0]  w_wr_addr;
    logic [STT_ENTRY_W-1:0] w_wr_data;
    logic [STT_ENTRY_W-1:0] w_main_rd;
    logic [STT_ENTRY_W-1:0] w_quies_rd;
    logic                   w_pop;

    t_stt_entry             w_main_ent;
    t_stt_entry             w_quies_ent;
    t_stt_entry             w_new_ent;
    logic                   w_skip_wr;
    t_stt_out               w_result;

    // table memories
    stt_ram #(
        .WIDTH (STT_ENTRY_W),
        .DEPTH (Depth)
    ) u_main_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_main),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_main_rd)
    );

    stt_ram #(
        .WIDTH (STT_ENTRY_W),
        .DEPTH (Depth)
    ) u_quies_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_quies),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_quies_rd)
    );

    assign w_rd_addr   = i_q_job.key_lo[INDEX_BITS-1:0];
    assign w_main_ent  = t_stt_entry'(w_main_rd);
    assign w_quies_ent = t_stt_entry'(w_quies_rd);

    // evaluate the current job against the entries read
    always_comb begin
        logic               v_m_tag_eq;
        logic               v_sel_ok;
        t_stt_entry         v_sel;
        logic signed [15:0] v_lo;
        logic signed [15:0] v_hi;

        v_m_tag_eq = (w_main_ent.tag == r_cur.tag);

        // update path: skip the write when the main entry for the same position is deeper
        w_skip_wr       = v_m_tag_eq && (w_main_ent.depth > r_cur.depth);
        w_new_ent.tag   = r_cur.tag;
        w_new_ent.score = r_cur.score;
        w_new_ent.depth = r_cur.depth;
        if (r_cur.score < r_cur.alpha) begin
            w_new_ent.kind = KIND_UPPER;
        end else if (r_cur.score >= r_cur.beta) begin
            w_new_ent.kind = KIND_LOWER;
        end else begin
            w_new_ent.kind = KIND_EXACT;
        end

        // read path: pick the entry that applies
        if (!r_cur.is_quies) begin
            v_sel    = w_main_ent;
            v_sel_ok = v_m_tag_eq && (w_main_ent.depth >= r_cur.depth);
        end else if (v_m_tag_eq) begin
            v_sel    = w_main_ent;
            v_sel_ok = 1'b1;
        end else begin
            v_sel    = w_quies_ent;
            v_sel_ok = (w_quies_ent.tag == r_cur.tag) &&
                       (w_quies_ent.depth >= r_cur.depth);
        end

        v_lo                  = r_cur.alpha;
        v_hi                  = r_cur.beta;
        w_result.hit          = 1'b0;
        w_result.result_value = '0;
        if (v_sel_ok) begin
            if (v_sel.kind == KIND_EXACT) begin
                w_result.hit          = 1'b1;
                w_result.result_value = v_sel.score;
            end else begin
                // bound entry tightens the window
                if (v_sel.kind == KIND_UPPER && v_sel.score < v_hi) begin
                    v_hi = v_sel.score;
                end else if (v_sel.kind == KIND_LOWER && v_sel.score > v_lo) begin
                    v_lo = v_sel.score;
                end
                if (v_lo >= v_hi) begin
                    w_result.hit          = 1'b1;
                    w_result.result_value = v_sel.score;
                end
            end
        end
        w_result.alpha_out = v_lo;
        w_result.beta_out  = v_hi;
    end

    // sequencer: clear sweep, read, evaluate
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        w_rd_en     = 1'b0;
        w_pop       = 1'b0;
        w_wr_main   = 1'b0;
        w_wr_quies  = 1'b0;
        w_wr_addr   = r_cur.key_lo[INDEX_BITS-1:0];
        w_wr_data   = STT_ENTRY_W'(w_new_ent);

        unique case (r_state)
            ST_CLEAR: begin
                w_wr_main  = 1'b1;
                w_wr_quies = 1'b1;
                w_wr_addr  = r_clr_addr;
                w_wr_data  = '0;
                n_clr_addr = r_clr_addr + {{(INDEX_BITS-1){1'b0}}, 1'b1};
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    w_pop   = 1'b1;
                    w_rd_en = 1'b1;
                    n_cur   = i_q_job;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_cur.is_update) begin
                    w_wr_main  = !w_skip_wr && !r_cur.is_quies;
                    w_wr_quies = !w_skip_wr && r_cur.is_quies;
                    n_state    = ST_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = w_result;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_out_word <= n_out_word;
    end

    assign o_back_stat.clear_done = (r_state != ST_CLEAR);
    assign o_back_stat.pop        = w_pop;
    assign o_out_valid            = r_out_valid;
    assign o_out_word             = r_out_word;

endmodule

>>> src/search_transposition_table.sv
// Flow: an accepted word is queued; the back end pops it and reads both tables,
// then evaluates the entries and writes the update or registers the result.
// Each word is finished before the next is popped; a result waits on i_out_ready.
// Reset: synchronous, active low; then a clearing pass over all 2^INDEX_BITS entries
// zeroes both tables, with o_in_ready low until it ends.
`timescale 1ns / 1ps
`include "search_transposition_table_defines.svh"

module search_transposition_table
    import stt_pkg::*;
#(
    parameter int unsigned INDEX_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_stt_in  i_in_word,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_stt_out o_out_word
);

    logic           w_q_valid;
    t_stt_job       w_q_job;
    t_stt_back_stat w_back_stat;

    // accept and classify
    stt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_q_valid   (w_q_valid),
        .o_q_job     (w_q_job),
        .i_back_stat (w_back_stat)
    );

    // table access and evaluation
    stt_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_q_job),
        .o_back_stat (w_back_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // checks
    `STT_ASSERT_IMPLIES(a_pop_needs_word, i_clk, i_rst_n, w_back_stat.pop, w_q_valid)
    `STT_ASSERT_IMPLIES(a_no_accept_in_clear, i_clk, i_rst_n, i_in_valid && o_in_ready, w_back_stat.clear_done)
    `STT_ASSERT_NEXT(a_clear_stays_done, i_clk, i_rst_n, w_back_stat.clear_done, w_back_stat.clear_done)

endmodule
